// File: rtl/kvp_pkg.sv
// Package for the keyframe vertex projection block: field widths, register
// codes, reset values and the payload structs shared by all rtl files.
// No dependencies.
package kvp_pkg;

   localparam int POS_W    = 24;
   localparam int ROT_W    = 32;
   localparam int HS_W     = 31;
   localparam int OFS_W    = 24;
   localparam int BLEND_W  = 9;
   localparam int CY_W     = 13;
   localparam int SCR_W    = 20;
   localparam int DEPTH_W  = 23;
   localparam int FRAC_POS = 8;
   localparam int FRAC_ROT = 16;
   localparam int TZ_W     = POS_W + ROT_W + 2 - FRAC_ROT;
   localparam int QB       = 20;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam int HALF_Q8  = 128;
   localparam int HALF_Q16 = 32768;

   localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(256);

   localparam logic signed [ROT_W-1:0] ROT_COS_RST = ROT_W'(65536);
   localparam logic [HS_W-1:0]         HEIGHT_SCALE_RST = HS_W'(65536);

   typedef enum logic [2:0] {
      REG_ROT_COS,
      REG_ROT_SIN,
      REG_HEIGHT_SCALE,
      REG_DEPTH_OFS,
      REG_SIDE_OFS,
      REG_HEIGHT_OFS,
      REG_BLEND,
      REG_CENTER_Y
   } reg_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0] first_x;
      logic signed [POS_W-1:0] first_y;
      logic signed [POS_W-1:0] first_z;
      logic signed [POS_W-1:0] second_x;
      logic signed [POS_W-1:0] second_y;
      logic signed [POS_W-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] screen_x;
      logic signed [SCR_W-1:0] screen_y;
      logic [DEPTH_W-1:0]      depth;
      logic                    visible;
   } rsp_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] rot_cos_scaled;
      logic signed [ROT_W-1:0] rot_sin_scaled;
      logic [HS_W-1:0]         height_scale;
      logic signed [OFS_W-1:0] depth_offset;
      logic signed [OFS_W-1:0] side_offset;
      logic signed [OFS_W-1:0] height_offset;
      logic [BLEND_W-1:0]      blend;
      logic signed [CY_W-1:0]  center_y;
   } cfg_type;

   typedef struct packed {
      logic signed [TZ_W-1:0] tz;
      logic signed [TZ_W-1:0] tx;
      logic signed [TZ_W-1:0] dz;
   } xf_type;

endpackage

// File: rtl/kvp_csr.sv
// Configuration register file with an APB-style write and read port.
// Depends on kvp_pkg.
module kvp_csr #(
   parameter int SCREEN_HEIGHT = 200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kvp_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [kvp_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [kvp_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output kvp_pkg::cfg_type              cfg
);
   import kvp_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   cfg_type     cfg_rst;
   reg_idx_type idx;
   logic        wr;

   assign idx        = reg_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_rst                = '0;
      cfg_rst.rot_cos_scaled = ROT_COS_RST;
      cfg_rst.height_scale   = HEIGHT_SCALE_RST;
      cfg_rst.center_y       = CY_W'(SCREEN_HEIGHT / 2);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_ROT_COS:      cfg_in.rot_cos_scaled = csr_pwdata[ROT_W-1:0];
            REG_ROT_SIN:      cfg_in.rot_sin_scaled = csr_pwdata[ROT_W-1:0];
            REG_HEIGHT_SCALE: cfg_in.height_scale   = csr_pwdata[HS_W-1:0];
            REG_DEPTH_OFS:    cfg_in.depth_offset   = csr_pwdata[OFS_W-1:0];
            REG_SIDE_OFS:     cfg_in.side_offset    = csr_pwdata[OFS_W-1:0];
            REG_HEIGHT_OFS:   cfg_in.height_offset  = csr_pwdata[OFS_W-1:0];
            REG_BLEND:        cfg_in.blend          = csr_pwdata[BLEND_W-1:0];
            REG_CENTER_Y:     cfg_in.center_y       = csr_pwdata[CY_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_ROT_COS:      csr_prdata = CSR_DW'(cfg_ff.rot_cos_scaled);
         REG_ROT_SIN:      csr_prdata = CSR_DW'(cfg_ff.rot_sin_scaled);
         REG_HEIGHT_SCALE: csr_prdata = CSR_DW'(cfg_ff.height_scale);
         REG_DEPTH_OFS:    csr_prdata = CSR_DW'(cfg_ff.depth_offset);
         REG_SIDE_OFS:     csr_prdata = CSR_DW'(cfg_ff.side_offset);
         REG_HEIGHT_OFS:   csr_prdata = CSR_DW'(cfg_ff.height_offset);
         REG_BLEND:        csr_prdata = CSR_DW'(cfg_ff.blend);
         REG_CENTER_Y:     csr_prdata = CSR_DW'(cfg_ff.center_y);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_rst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/kvp_xform.sv
// Five-stage transform pipeline: keyframe blend, rotation and scale, offsets.
// Depends on kvp_pkg.
module kvp_xform (
   input  logic             clock,
   input  logic             reset,
   input  kvp_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  kvp_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output kvp_pkg::xf_type  out_data
);
   import kvp_pkg::*;

   localparam int NS   = 5;
   localparam int BP_W = POS_W + BLEND_W + 1;
   localparam int BS_W = BP_W + 1;
   localparam int PR_W = POS_W + ROT_W;
   localparam int RS_W = PR_W + 1;
   localparam int RR_W = RS_W - FRAC_ROT;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   hold;
   logic [NS-1:0] en;

   logic [BLEND_W-1:0]      w;
   logic [BLEND_W-1:0]      wf;
   logic signed [POS_W-1:0] fpos [3];
   logic signed [POS_W-1:0] spos [3];
   logic signed [BP_W-1:0]  pf_ff [3];
   logic signed [BP_W-1:0]  pf_in [3];
   logic signed [BP_W-1:0]  ps_ff [3];
   logic signed [BP_W-1:0]  ps_in [3];
   logic signed [BS_W-1:0]  sum [3];
   logic signed [POS_W-1:0] l_ff [3];
   logic signed [POS_W-1:0] l_in [3];
   logic signed [PR_W-1:0]  pxc_ff, pys_ff, pxs_ff, pyc_ff, pzh_ff;
   logic signed [PR_W-1:0]  pxc_in, pys_in, pxs_in, pyc_in, pzh_in;
   logic signed [RS_W-1:0]  az, ax, ah;
   logic signed [RR_W-1:0]  tzr_ff, txr_ff, dzr_ff;
   logic signed [RR_W-1:0]  tzr_in, txr_in, dzr_in;
   xf_type                  out_ff;
   xf_type                  out_in;

   always_comb begin
      hold[NS] = out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = vld_ff[i] & hold[i+1];
      end
      en = ~hold[NS-1:0];
   end

   assign in_stall  = hold[0];
   assign out_valid = vld_ff[NS-1];
   assign out_data  = out_ff;

   assign fpos[0] = in_data.first_x;
   assign fpos[1] = in_data.first_y;
   assign fpos[2] = in_data.first_z;
   assign spos[0] = in_data.second_x;
   assign spos[1] = in_data.second_y;
   assign spos[2] = in_data.second_z;

   always_comb begin
      w  = (cfg.blend > BLEND_ONE) ? BLEND_ONE : cfg.blend;
      wf = BLEND_ONE - w;
      for (int a = 0; a < 3; a++) begin
         pf_in[a] = fpos[a] * $signed({1'b0, wf});
         ps_in[a] = spos[a] * $signed({1'b0, w});
         sum[a]   = BS_W'(pf_ff[a]) + BS_W'(ps_ff[a]) + BS_W'(HALF_Q8);
         l_in[a]  = sum[a][FRAC_POS +: POS_W];
      end
   end

   always_comb begin
      pxc_in = l_ff[0] * cfg.rot_cos_scaled;
      pys_in = l_ff[1] * cfg.rot_sin_scaled;
      pxs_in = l_ff[0] * cfg.rot_sin_scaled;
      pyc_in = l_ff[1] * cfg.rot_cos_scaled;
      pzh_in = l_ff[2] * $signed({1'b0, cfg.height_scale});
      az     = RS_W'(pxc_ff) - RS_W'(pys_ff) + RS_W'(HALF_Q16);
      ax     = RS_W'(pxs_ff) + RS_W'(pyc_ff) + RS_W'(HALF_Q16);
      ah     = RS_W'(pzh_ff) + RS_W'(HALF_Q16);
      tzr_in = az[FRAC_ROT +: RR_W];
      txr_in = ax[FRAC_ROT +: RR_W];
      dzr_in = ah[FRAC_ROT +: RR_W];
      out_in.tz = TZ_W'(tzr_ff) + TZ_W'(cfg.depth_offset);
      out_in.tx = TZ_W'(txr_ff) + TZ_W'(cfg.side_offset);
      out_in.dz = TZ_W'(dzr_ff) + TZ_W'(cfg.height_offset);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pf_ff <= pf_in;
         ps_ff <= ps_in;
      end
      if (en[1]) begin
         l_ff <= l_in;
      end
      if (en[2]) begin
         pxc_ff <= pxc_in;
         pys_ff <= pys_in;
         pxs_ff <= pxs_in;
         pyc_ff <= pyc_in;
         pzh_ff <= pzh_in;
      end
      if (en[3]) begin
         tzr_ff <= tzr_in;
         txr_ff <= txr_in;
         dzr_ff <= dzr_in;
      end
      if (en[4]) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/kvp_proj.sv
// Projection pipeline: numerator build, restoring divider with one quotient
// bit per stage, saturation and the result register. Depends on kvp_pkg.
module kvp_proj #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic             clock,
   input  logic             reset,
   input  kvp_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_stall,
   input  kvp_pkg::xf_type  in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output kvp_pkg::rsp_type out_data
);
   import kvp_pkg::*;

   localparam int F8    = SCREEN_WIDTH * 8;
   localparam int F8_W  = $clog2(F8 + 1);
   localparam int MP_W  = TZ_W + F8_W + 1;
   localparam int NUM_W = MP_W + 2;
   localparam int SW    = QB + 3;
   localparam int DV0   = 3;
   localparam int OUT_S = DV0 + QB + 1;
   localparam int NS    = OUT_S + 1;

   localparam logic [F8_W-1:0]        F8V       = F8_W'(F8);
   localparam logic signed [TZ_W-1:0] DEPTH_ONE = TZ_W'(256);
   localparam logic signed [TZ_W-1:0] DEPTH_MAX = TZ_W'((2 ** DEPTH_W) - 1);
   localparam logic signed [SW-1:0]   SAT_HI    = SW'((2 ** (SCR_W - 1)) - 1);
   localparam logic signed [SW-1:0]   SAT_LO    = SW'(-(2 ** (SCR_W - 1)));

   typedef struct packed {
      logic [TZ_W-1:0]        rem_x;
      logic [TZ_W-1:0]        rem_y;
      logic [QB-1:0]          q_x;
      logic [QB-1:0]          q_y;
      logic [QB-1:0]          low_x;
      logic [QB-1:0]          low_y;
      logic                   ovf_x;
      logic                   ovf_y;
      logic                   neg_x;
      logic                   neg_y;
      logic signed [TZ_W-1:0] tz;
      logic                   vis;
   } dv_type;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   hold;
   logic [NS-1:0] en;

   logic signed [MP_W-1:0]  pxp_ff, pyp_ff, pxp_in, pyp_in;
   logic signed [TZ_W-1:0]  tz0_ff, tz1_ff, tz2_ff;
   logic                    vis0_ff, vis1_ff, vis2_ff, vis0_in;
   logic signed [NUM_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [NUM_W-1:0]        mx_ff, my_ff, mx_in, my_in;
   logic                    negx_ff, negy_ff;
   logic [TZ_W-1:0]         d1, d2;
   dv_type                  dv_ff [QB+1];
   dv_type                  dv_in [QB+1];
   rsp_type                 rsp_ff, rsp_in;

   logic [TZ_W:0]           tx_t, ty_t, dk_t;
   logic [QB:0]             qmx, qmy;
   logic signed [QB+1:0]    qsx, qsy;
   logic signed [SW-1:0]    sxw, syw;

   function automatic logic signed [SCR_W-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[SCR_W-1:0];
   endfunction

   always_comb begin
      hold[NS] = out_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         hold[i] = vld_ff[i] & hold[i+1];
      end
      en = ~hold[NS-1:0];
   end

   assign in_stall  = hold[0];
   assign out_valid = vld_ff[OUT_S];
   assign out_data  = rsp_ff;

   always_comb begin
      pxp_in  = in_data.tx * $signed({1'b0, F8V});
      pyp_in  = in_data.dz * $signed({1'b0, F8V});
      vis0_in = in_data.tz >= DEPTH_ONE;
      nx_in   = (NUM_W'(pxp_ff) <<< 1) + NUM_W'(tz0_ff);
      ny_in   = (NUM_W'(pyp_ff) <<< 1) + NUM_W'(tz0_ff);
      d1      = {tz1_ff[TZ_W-2:0], 1'b0};
      mx_in   = nx_ff[NUM_W-1] ? (~nx_ff + NUM_W'(d1)) : nx_ff;
      my_in   = ny_ff[NUM_W-1] ? (~ny_ff + NUM_W'(d1)) : ny_ff;
   end

   always_comb begin
      d2             = {tz2_ff[TZ_W-2:0], 1'b0};
      dv_in[0].rem_x = TZ_W'(mx_ff >> QB);
      dv_in[0].rem_y = TZ_W'(my_ff >> QB);
      dv_in[0].q_x   = '0;
      dv_in[0].q_y   = '0;
      dv_in[0].low_x = mx_ff[QB-1:0];
      dv_in[0].low_y = my_ff[QB-1:0];
      dv_in[0].ovf_x = (mx_ff >> QB) >= NUM_W'(d2);
      dv_in[0].ovf_y = (my_ff >> QB) >= NUM_W'(d2);
      dv_in[0].neg_x = negx_ff;
      dv_in[0].neg_y = negy_ff;
      dv_in[0].tz    = tz2_ff;
      dv_in[0].vis   = vis2_ff;
      tx_t = '0;
      ty_t = '0;
      dk_t = '0;
      for (int k = 1; k <= QB; k++) begin
         dv_in[k] = dv_ff[k-1];
         dk_t = {dv_ff[k-1].tz[TZ_W-2:0], 1'b0} & {1'b0, {TZ_W{1'b1}}};
         tx_t = {dv_ff[k-1].rem_x, dv_ff[k-1].low_x[QB-k]};
         ty_t = {dv_ff[k-1].rem_y, dv_ff[k-1].low_y[QB-k]};
         if (tx_t >= dk_t) begin
            dv_in[k].rem_x = TZ_W'(tx_t - dk_t);
         end else begin
            dv_in[k].rem_x = tx_t[TZ_W-1:0];
         end
         if (ty_t >= dk_t) begin
            dv_in[k].rem_y = TZ_W'(ty_t - dk_t);
         end else begin
            dv_in[k].rem_y = ty_t[TZ_W-1:0];
         end
         dv_in[k].q_x = {dv_ff[k-1].q_x[QB-2:0], tx_t >= dk_t};
         dv_in[k].q_y = {dv_ff[k-1].q_y[QB-2:0], ty_t >= dk_t};
      end
   end

   always_comb begin
      qmx = dv_ff[QB].ovf_x ? (QB+1)'(1 << QB) : {1'b0, dv_ff[QB].q_x};
      qmy = dv_ff[QB].ovf_y ? (QB+1)'(1 << QB) : {1'b0, dv_ff[QB].q_y};
      qsx = dv_ff[QB].neg_x ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
      qsy = dv_ff[QB].neg_y ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});
      sxw = SW'($signed({1'b0, F8V})) + SW'(qsx);
      syw = (SW'(cfg.center_y) <<< 4) - SW'(qsy);
      rsp_in = '0;
      if (dv_ff[QB].vis) begin
         rsp_in.screen_x = sat(sxw);
         rsp_in.screen_y = sat(syw);
         rsp_in.depth    = (dv_ff[QB].tz > DEPTH_MAX) ? {DEPTH_W{1'b1}}
                                                      : dv_ff[QB].tz[DEPTH_W-1:0];
         rsp_in.visible  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pxp_ff  <= pxp_in;
         pyp_ff  <= pyp_in;
         tz0_ff  <= in_data.tz;
         vis0_ff <= vis0_in;
      end
      if (en[1]) begin
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         tz1_ff  <= tz0_ff;
         vis1_ff <= vis0_ff;
      end
      if (en[2]) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         negx_ff <= nx_ff[NUM_W-1];
         negy_ff <= ny_ff[NUM_W-1];
         tz2_ff  <= tz1_ff;
         vis2_ff <= vis1_ff;
      end
      for (int k = 0; k <= QB; k++) begin
         if (en[DV0+k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      if (en[OUT_S]) begin
         rsp_ff <= rsp_in;
      end
   end

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[OUT_S] && !rsp_ff.visible |->
         rsp_ff.screen_x == '0 && rsp_ff.screen_y == '0 && rsp_ff.depth == '0)
      else $error("Rejected vertex carries nonzero fields.");

   a_vis_depth: assert property (@(posedge clock) disable iff (reset)
      vld_ff[OUT_S] && rsp_ff.visible |-> rsp_ff.depth >= DEPTH_W'(256))
      else $error("Visible vertex with depth below one.");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DV0+QB] && dv_ff[QB].vis && !dv_ff[QB].ovf_x |->
         dv_ff[QB].rem_x < {dv_ff[QB].tz[TZ_W-2:0], 1'b0})
      else $error("Divider remainder not below the divisor.");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> out_stall && vld_ff[OUT_S])
      else $error("Pipeline stalls without a blocked result.");

endmodule

// File: rtl/keyframe_vertex_project.sv
// Top level of the keyframe vertex projection block.
// Depends on kvp_pkg, kvp_csr, kvp_xform and kvp_proj.
//
// One vertex (two keyframe positions, Q16.8) enters on the req_ channel per
// transfer; each vertex gives exactly one result on the rsp_ channel with
// screen x and y (Q16.4, saturated), depth (Q15.8) and a visible flag.
// Results leave in input order.
// Five transform stages feed a projection pipeline whose restoring divider
// retires one quotient bit per stage over 20 stages. A new vertex is taken
// every cycle while req_stall is low. Configuration is written through the
// csr_ port while the block is idle, a user rule that the block does not
// enforce. Synchronous reset empties the pipeline and loads the register
// defaults. When rsp_stall is high the result holds, the stages behind it
// fill their empty slots, and req_stall rises once every stage is occupied.
module keyframe_vertex_project #(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  kvp_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output kvp_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [kvp_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [kvp_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [kvp_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import kvp_pkg::*;

   cfg_type cfg;
   xf_type  xf_data;
   logic    xf_valid;
   logic    xf_stall;

   kvp_csr #(
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kvp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (xf_valid),
      .out_stall (xf_stall),
      .out_data  (xf_data)
   );

   kvp_proj #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_proj (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (xf_valid),
      .in_stall  (xf_stall),
      .in_data   (xf_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// File: dv/keyframe_vertex_project_tb.sv
// Self-checking testbench for keyframe_vertex_project: vertex transforms and projections
// are predicted in the bench and compared with every response transfer.
// Depends on kvp_pkg and the keyframe_vertex_project rtl.
module keyframe_vertex_project_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kvp_pkg::*;

   localparam int SW = 320;
   localparam int SH = 200;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   keyframe_vertex_project #(.SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH)) uut (.*);

   cfg_type shadow_cfg;
   req_type vertex_queue[$];
   rsp_type projected_queue[$];
   int errors;
   int idle_cycles;
   int burst_left;
   int gap_left;
   int hold_off;
   int stall_mode;
   bit flood_req;
   bit req_taken;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint blend_axis(longint f, longint s, longint w);
      return floor_div(f * (256 - w) + s * w + 128, 256);
   endfunction

   function automatic rsp_type project_vertex(req_type v, cfg_type c);
      rsp_type r;
      longint w, lx, ly, lz, rc, rs, tz, tx, dz, f8, qx, qy;
      w = (c.blend > 256) ? 256 : longint'(c.blend);
      lx = blend_axis(longint'(v.first_x), longint'(v.second_x), w);
      ly = blend_axis(longint'(v.first_y), longint'(v.second_y), w);
      lz = blend_axis(longint'(v.first_z), longint'(v.second_z), w);
      rc = longint'(c.rot_cos_scaled);
      rs = longint'(c.rot_sin_scaled);
      tz = floor_div(lx * rc - ly * rs + 32768, 65536) + longint'(c.depth_offset);
      tx = floor_div(lx * rs + ly * rc + 32768, 65536) + longint'(c.side_offset);
      dz = floor_div(lz * longint'({1'b0, c.height_scale}) + 32768, 65536)
           + longint'(c.height_offset);
      r = '0;
      if (tz >= 256) begin
         f8 = SW * 8;
         qx = floor_div(2 * tx * f8 + tz, 2 * tz);
         qy = floor_div(2 * dz * f8 + tz, 2 * tz);
         r.screen_x = SCR_W'(sat(f8 + qx, -524288, 524287));
         r.screen_y = SCR_W'(sat(longint'(c.center_y) * 16 - qy, -524288, 524287));
         r.depth = DEPTH_W'(sat(tz, 0, 8388607));
         r.visible = 1'b1;
      end
      return r;
   endfunction

   task automatic write_reg(reg_idx_type idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(4 * int'(idx));
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_ROT_COS:      shadow_cfg.rot_cos_scaled = value;
         REG_ROT_SIN:      shadow_cfg.rot_sin_scaled = value;
         REG_HEIGHT_SCALE: shadow_cfg.height_scale = value[HS_W-1:0];
         REG_DEPTH_OFS:    shadow_cfg.depth_offset = value[OFS_W-1:0];
         REG_SIDE_OFS:     shadow_cfg.side_offset = value[OFS_W-1:0];
         REG_HEIGHT_OFS:   shadow_cfg.height_offset = value[OFS_W-1:0];
         REG_BLEND:        shadow_cfg.blend = value[BLEND_W-1:0];
         default:          shadow_cfg.center_y = value[CY_W-1:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [23:0] rand_pos(int mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($signed(16'($urandom)));
         default: return 24'($urandom_range(0, 20000) - 10000);
      endcase
   endfunction

   function automatic req_type rand_vertex();
      req_type v;
      int mode;
      mode = $urandom_range(0, 5);
      v.first_x = rand_pos(mode);
      v.first_y = rand_pos(mode);
      v.first_z = rand_pos(mode);
      v.second_x = rand_pos(mode);
      v.second_y = rand_pos(mode);
      v.second_z = rand_pos(mode);
      return v;
   endfunction

   task automatic wait_drained();
      while (vertex_queue.size() != 0 || projected_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(int count);
      repeat (count) vertex_queue.push_back(rand_vertex());
      wait_drained();
   endtask

   // Driver: bursts and gaps; a vertex is predicted when its transfer is taken.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         projected_queue.push_back(project_vertex(req_data, shadow_cfg));
         void'(vertex_queue.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_taken) begin
         end else if (vertex_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (flood_req || burst_left > 0) begin
            req_valid <= 1'b1;
            req_data <= vertex_queue[0];
            if (burst_left > 0) burst_left <= burst_left - 1;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else begin
            req_valid <= 1'b0;
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         end
      end
   end

   // Receiver stall pattern, with one long hold-off while the sender floods.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (projected_queue.size() == 0) begin
               $error("unexpected result transfer %p", rsp_data);
               errors++;
            end else begin
               exp_rsp = projected_queue.pop_front();
               if (rsp_data.screen_x !== exp_rsp.screen_x) begin
                  $error("screen_x expected %0d actual %0d", exp_rsp.screen_x, rsp_data.screen_x);
                  errors++;
               end
               if (rsp_data.screen_y !== exp_rsp.screen_y) begin
                  $error("screen_y expected %0d actual %0d", exp_rsp.screen_y, rsp_data.screen_y);
                  errors++;
               end
               if (rsp_data.depth !== exp_rsp.depth) begin
                  $error("depth expected %0d actual %0d", exp_rsp.depth, rsp_data.depth);
                  errors++;
               end
               if (rsp_data.visible !== exp_rsp.visible) begin
                  $error("visible expected %0b actual %0b", exp_rsp.visible, rsp_data.visible);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      req_type v;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      errors = 0;
      idle_cycles = 0;
      burst_left = 0;
      gap_left = 0;
      hold_off = 0;
      stall_mode = 1;
      flood_req = 1'b0;
      req_taken = 1'b0;
      shadow_cfg.rot_cos_scaled = ROT_COS_RST;
      shadow_cfg.rot_sin_scaled = '0;
      shadow_cfg.height_scale = HEIGHT_SCALE_RST;
      shadow_cfg.depth_offset = '0;
      shadow_cfg.side_offset = '0;
      shadow_cfg.height_offset = '0;
      shadow_cfg.blend = '0;
      shadow_cfg.center_y = CY_W'(SH / 2);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed vertices under reset defaults: near plane, extremes, rejection.
      v = '0;
      vertex_queue.push_back(v);
      v.first_x = 24'sd256;
      vertex_queue.push_back(v);
      v.first_x = 24'sd255;
      vertex_queue.push_back(v);
      v.first_x = 24'sd300; v.first_y = 24'h7FFFFF; v.first_z = 24'h800000;
      vertex_queue.push_back(v);
      v.first_y = 24'h800000; v.first_z = 24'h7FFFFF;
      vertex_queue.push_back(v);
      v = '0; v.first_x = 24'h7FFFFF; v.first_y = 24'h7FFFFF; v.first_z = 24'h7FFFFF;
      vertex_queue.push_back(v);
      v = '0; v.first_x = 24'h800000; v.first_y = 24'h800000;
      vertex_queue.push_back(v);
      v = '1;
      vertex_queue.push_back(v);
      wait_drained();

      // Blend at half, at one and above one.
      write_reg(REG_BLEND, 32'd128);
      v.first_x = 24'sd512; v.second_x = 24'sd1024; v.first_y = 24'sd3;
      v.second_y = -24'sd7; v.first_z = 24'h800000; v.second_z = 24'h7FFFFF;
      vertex_queue.push_back(v);
      wait_drained();
      write_reg(REG_BLEND, 32'd256);
      vertex_queue.push_back(v);
      wait_drained();
      write_reg(REG_BLEND, 32'h1FF);
      vertex_queue.push_back(v);
      v.second_x = 24'sd100;
      vertex_queue.push_back(v);
      wait_drained();

      // Extreme register settings.
      write_reg(REG_ROT_COS, 32'h7FFFFFFF);
      write_reg(REG_ROT_SIN, 32'h80000000);
      write_reg(REG_HEIGHT_SCALE, 32'h7FFFFFFF);
      write_reg(REG_DEPTH_OFS, 32'h007FFFFF);
      write_reg(REG_SIDE_OFS, 32'h00800000);
      write_reg(REG_HEIGHT_OFS, 32'h007FFFFF);
      write_reg(REG_CENTER_Y, 32'h00001000);
      run_phase(10);
      write_reg(REG_ROT_COS, 32'h80000000);
      write_reg(REG_ROT_SIN, 32'h7FFFFFFF);
      write_reg(REG_HEIGHT_SCALE, 32'h0);
      write_reg(REG_DEPTH_OFS, 32'h00800000);
      write_reg(REG_SIDE_OFS, 32'h007FFFFF);
      write_reg(REG_HEIGHT_OFS, 32'h00800000);
      write_reg(REG_CENTER_Y, 32'h00000FFF);
      write_reg(REG_BLEND, 32'd0);
      run_phase(8);

      // Realistic settings with random content; one phase floods a stalled receiver.
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(REG_ROT_COS, $urandom_range(0, 1) ? 32'($signed(18'($urandom)))
                                                    : $urandom);
         write_reg(REG_ROT_SIN, $urandom_range(0, 1) ? 32'($signed(18'($urandom)))
                                                    : $urandom);
         write_reg(REG_HEIGHT_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 262143)
                                                         : $urandom);
         write_reg(REG_DEPTH_OFS, $urandom_range(0, 1) ? $urandom_range(256, 200000)
                                                      : $urandom);
         write_reg(REG_SIDE_OFS, $urandom);
         write_reg(REG_HEIGHT_OFS, $urandom);
         write_reg(REG_BLEND, $urandom_range(0, 511));
         write_reg(REG_CENTER_Y, $urandom);
         if (ph == 3) begin
            flood_req = 1'b1;
            @(negedge clock);
            hold_off <= 300;
         end
         run_phase(200);
         flood_req = 1'b0;
      end

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: files.f
rtl/kvp_pkg.sv
rtl/kvp_csr.sv
rtl/kvp_xform.sv
rtl/kvp_proj.sv
rtl/keyframe_vertex_project.sv
dv/keyframe_vertex_project_tb.sv
